FILE: hdl/b128vlq_pkg.sv
// shared types and constants for the base-128 vlq decoder
// no dependencies
package b128vlq_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned GROUP_W  = 7;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned STATUS_W = 2;

  localparam logic [BYTE_W-1:0]  CONT_BYTE     = 8'h80;
  localparam logic [COUNT_W-1:0] FIRST_BYTE    = 4'd1;
  localparam logic [COUNT_W-1:0] LIMIT_BYTE    = 4'd10;
  localparam logic [VALUE_W-1:0] SAFE_LIMIT    = 64'hFFFF_FFFF_FFFF_FFFF >> GROUP_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] decoded_value;
    logic [COUNT_W-1:0] bytes_used;
  } result_t;

endpackage

FILE: hdl/b128vlq_in_stage.sv
// input register for one stream byte and its end flag
// depends on b128vlq_pkg
module b128vlq_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  b128vlq_pkg::in_item_t in_item,
  output logic                 item_valid,
  output b128vlq_pkg::in_item_t item,
  input  logic                 item_take
);
  import b128vlq_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     accept;

  assign in_stall   = valid_r && !item_take;
  assign accept     = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: hdl/b128vlq_step.sv
// decode step: accumulator, byte count and per-byte result logic
// depends on b128vlq_pkg
module b128vlq_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  b128vlq_pkg::in_item_t item,
  output logic                  item_take,
  input  logic                  res_ready,
  output logic                  res_push,
  output b128vlq_pkg::result_t  res
);
  import b128vlq_pkg::*;

  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] cnt;
  logic [VALUE_W-1:0] shifted;
  logic               cont;
  logic               bad;
  logic               has_res;

  assign cnt     = cnt_r + 4'd1;
  assign cont    = item.data_byte[BYTE_W-1];
  assign shifted = {acc_r[VALUE_W-GROUP_W-1:0], item.data_byte[GROUP_W-1:0]};

  assign bad = (cnt == FIRST_BYTE && item.data_byte == CONT_BYTE)
            || (cnt > LIMIT_BYTE)
            || (cnt == LIMIT_BYTE && acc_r > SAFE_LIMIT);

  assign has_res   = bad || !cont || item.end_of_stream;
  assign item_take = item_valid && (!has_res || res_ready);
  assign res_push  = item_take && has_res;

  always_comb begin
    res.bytes_used    = cnt;
    res.decoded_value = '0;
    if (bad) begin
      res.status = ST_BAD;
    end else if (!cont) begin
      res.status        = ST_OK;
      res.decoded_value = shifted;
    end else begin
      res.status = ST_TRUNC;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (item_take) begin
      if (has_res) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = shifted;
        cnt_nxt = cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/b128vlq_out_stage.sv
// result register toward the output channel
// depends on b128vlq_pkg
module b128vlq_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_push,
  input  b128vlq_pkg::result_t res,
  output logic                 res_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output b128vlq_pkg::result_t out_res
);
  import b128vlq_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign res_ready = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_push) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_r <= res;
    end
  end

endmodule

FILE: hdl/base128_vlq_decoder_64bit_core.sv
// base-128 vlq decoder core: one stream byte per request, 64-bit values
// path: the byte that ends a value is held in the input register, then its result in the result register
// throughput: one byte per cycle while out_stall does not hold the result register
// reset: synchronous active-low rst_n empties both registers and clears accumulator and count
// depends on b128vlq_pkg, b128vlq_in_stage, b128vlq_step, b128vlq_out_stage
module base128_vlq_decoder_64bit_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [b128vlq_pkg::BYTE_W-1:0]          in_data_byte,
  input  logic                                    in_end_of_stream,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [b128vlq_pkg::STATUS_W-1:0]        out_status,
  output logic [b128vlq_pkg::VALUE_W-1:0]         out_decoded_value,
  output logic [b128vlq_pkg::COUNT_W-1:0]         out_bytes_used
);
  import b128vlq_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     item_take;
  logic     res_ready;
  logic     res_push;
  result_t  res;
  result_t  out_res;

  assign in_item.data_byte     = in_data_byte;
  assign in_item.end_of_stream = in_end_of_stream;

  b128vlq_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  b128vlq_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_ready  (res_ready),
    .res_push   (res_push),
    .res        (res)
  );

  b128vlq_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_decoded_value = out_res.decoded_value;
  assign out_bytes_used    = out_res.bytes_used;

endmodule

FILE: hdl/b128vlq_chk.sv
// port-level checks for the vlq decoder core, bound to the top level
// depends on b128vlq_pkg and base128_vlq_decoder_64bit_core
module b128vlq_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [b128vlq_pkg::STATUS_W-1:0]   out_status,
  input logic [b128vlq_pkg::VALUE_W-1:0]    out_decoded_value,
  input logic [b128vlq_pkg::COUNT_W-1:0]    out_bytes_used
);
  import b128vlq_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_decoded_value) && $stable(out_bytes_used))
    else $error("stalled result changed");

  // only success carries a value
  a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_decoded_value == '0)
    else $error("non-success result with nonzero value");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bytes_used >= 4'd1 && out_bytes_used <= 4'd11)
    else $error("bytes_used out of range");

  // truncation cannot follow more than ten bytes
  a_trunc_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TRUNC |-> out_bytes_used <= LIMIT_BYTE)
    else $error("truncated result too long");

endmodule

bind base128_vlq_decoder_64bit_core b128vlq_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_decoded_value (out_decoded_value),
  .out_bytes_used    (out_bytes_used)
);

FILE: tb/base128_vlq_decoder_64bit_core_tb.sv
// testbench for base128_vlq_decoder_64bit_core: sends stream bytes with random gaps and stalls,
// predicts each decoded value, status and byte count, and checks the results in order
// depends on b128vlq_pkg and the decoder core
module base128_vlq_decoder_64bit_core_tb;
  import b128vlq_pkg::*;

  localparam int ITEM_TARGET = 950;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 8;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                in_end_of_stream = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_decoded_value;
  logic [COUNT_W-1:0]  out_bytes_used;

  result_t            pending_results[$];
  logic [VALUE_W-1:0] value_acc = '0;
  logic [COUNT_W-1:0] value_len = '0;
  int                 items_sent = 0;
  int                 mismatches = 0;
  int                 idle_cycles = 0;
  int                 stall_left = 0;
  bit                 in_gap_on = 1'b0;
  bit                 stall_on = 1'b0;

  base128_vlq_decoder_64bit_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_end_of_stream(in_end_of_stream),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_decoded_value(out_decoded_value),
    .out_bytes_used(out_bytes_used)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic eos,
                                     output result_t r);
    logic [COUNT_W-1:0] n;
    logic [VALUE_W-1:0] nxt;
    bit                 done;
    n = value_len + 4'd1;
    nxt = {value_acc[VALUE_W-GROUP_W-1:0], b[GROUP_W-1:0]};
    done = 1'b1;
    r.status = ST_OK;
    r.decoded_value = '0;
    r.bytes_used = n;
    if (n == FIRST_BYTE && b == CONT_BYTE) begin
      r.status = ST_BAD;
    end else if (n > LIMIT_BYTE || (n == LIMIT_BYTE && value_acc > SAFE_LIMIT)) begin
      r.status = ST_BAD;
    end else if (!b[BYTE_W-1]) begin
      r.decoded_value = nxt;
    end else if (eos) begin
      r.status = ST_TRUNC;
    end else begin
      done = 1'b0;
    end
    if (done) begin
      value_acc = '0;
      value_len = '0;
    end else begin
      value_acc = nxt;
      value_len = n;
    end
    return done;
  endfunction

  function automatic int pick_gap(bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
    int      gap;
    result_t r;
    gap = pick_gap(in_gap_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (decode_byte(b, eos, r)) pending_results.push_back(r);
    items_sent++;
  endtask

  // first byte carries the given group, later groups are random
  task automatic send_run(input int first, input int len, input bit last_cont,
                          input bit eos_last);
    int g;
    for (int i = 0; i < len; i++) begin
      g = (i == 0) ? first : $urandom_range(0, 127);
      send_byte({(i < len - 1) || last_cont, g[GROUP_W-1:0]}, (i == len - 1) && eos_last);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(CONT_BYTE, 1'b0);
    send_byte(CONT_BYTE, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h00, 1'b0);
    // largest value that fits in 64 bits
    send_byte(8'h81, 1'b0);
    repeat (8) send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_length_limits();
    // accumulator exactly at the safe bound, then an eleventh byte
    send_byte(8'h81, 1'b0);
    repeat (8) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // one above the bound on the tenth byte
    send_byte(8'h82, 1'b0);
    repeat (8) send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    // overflow on a last byte of the stream
    send_byte(8'hFF, 1'b0);
    repeat (8) send_byte(8'hC3, 1'b0);
    send_byte(8'h95, 1'b1);
  endtask

  task automatic test_random_streams();
    int kind;
    int len;
    int first;
    int next_phase;
    bit paused;
    next_phase = 0;
    paused = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_phase) begin
        in_gap_on = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
        next_phase = items_sent + 120;
      end
      if (!paused && items_sent >= ITEM_TARGET / 2) begin
        drain_results();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        case ($urandom_range(0, 3))
          0: len = $urandom_range(1, 2);
          3: len = 10;
          default: len = $urandom_range(3, 9);
        endcase
        if (len == 10) first = $urandom_range(1, 3);
        else if (len == 1) first = $urandom_range(0, 127);
        else first = $urandom_range(1, 127);
        if (kind < 50) send_run(first, len, 1'b0, $urandom_range(0, 3) == 0);
        else send_run(first, len, 1'b1, 1'b1);
      end else if (kind < 75) begin
        send_run(1, 11, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (kind < 80) begin
        send_byte(CONT_BYTE, 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap(stall_on);
      out_stall <= stall_left > 0;
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d value %h bytes %0d",
                               out_status, out_decoded_value, out_bytes_used));
      end else begin
        want = pending_results.pop_front();
        if (out_status != want.status || out_decoded_value != want.decoded_value ||
            out_bytes_used != want.bytes_used) begin
          note_failure($sformatf(
            "result mismatch: expected status %0d value %h bytes %0d, got %0d %h %0d",
            want.status, want.decoded_value, want.bytes_used,
            out_status, out_decoded_value, out_bytes_used));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("base128_vlq_decoder_64bit_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    drain_results();
    test_length_limits();
    test_random_streams();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("base128_vlq_decoder_64bit_core regression: pass");
    end else begin
      $display("base128_vlq_decoder_64bit_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/b128vlq_pkg.sv
hdl/b128vlq_in_stage.sv
hdl/b128vlq_step.sv
hdl/b128vlq_out_stage.sv
hdl/base128_vlq_decoder_64bit_core.sv
hdl/b128vlq_chk.sv
tb/base128_vlq_decoder_64bit_core_tb.sv
